/* src/lwfc_pkg.sv */
// Package for the lamp wake-up fade controller: codes, widths and the level duty lookup.
package lwfc_pkg;

    // Field and register widths
    localparam int DUTY_W    = 7;
    localparam int LEVEL_W   = 2;
    localparam int MODE_W    = 3;
    localparam int SECONDS_W = 12;
    localparam int ELAPSED_W = 22;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SWITCH_ON  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SWITCH_OFF = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_LEVEL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_WAKEUP = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SECONDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_DUTY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_DUTY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DUTY    = 2'd3;

    // Brightness levels
    localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH   = 2'd3;

    // Duty for a level, saturated to full duty
    function automatic logic [DUTY_W-1:0] level_duty(
        input logic [LEVEL_W-1:0] lvl,
        input logic [DUTY_W-1:0]  low_d,
        input logic [DUTY_W-1:0]  med_d,
        input logic [DUTY_W-1:0]  high_d
    );
        logic [DUTY_W-1:0] d;
        case (lvl)
            LEVEL_LOW:    d = low_d;
            LEVEL_MEDIUM: d = med_d;
            default:      d = high_d;
        endcase
        return (d > DUTY_FULL) ? DUTY_FULL : d;
    endfunction

endpackage

/* src/light_wakeup_fade_controller_top.sv */
// Top level of the lamp wake-up fade controller: control, ramp arithmetic and handshakes.
//
// One input beat gives one result beat. Switch, level and wake-up beats, and ticks
// with no ramp running, go from accept straight to the output load. A tick during a
// running ramp steps the elapsed count and forms the ramp total when it is accepted,
// then runs a shift-add multiply of elapsed by the target duty, a compare step and a
// restoring division by the ramp total, one quotient bit each step, and is then
// loaded into the output register once it is free. The tick that ends the ramp skips
// the division.
// A new beat is accepted only once the previous one has reached the output
// register; a finished result waits there while the next beat is taken.
// Ramp-seconds writes above MAX_RAMP_SECONDS are dropped.
module light_wakeup_fade_controller_top
    import lwfc_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = 1000,
    parameter int unsigned MAX_RAMP_SECONDS = 3599
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [LEVEL_W-1:0]   i_level_select,
    input  logic                 i_wakeup_value,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DUTY_W-1:0]    o_duty_percent,
    output logic                 o_ramp_running,
    output logic [LEVEL_W-1:0]   o_level_now
);

    // Datapath widths
    localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int TW    = SECONDS_W + TPS_W;            // ramp total in ticks
    localparam int PW    = ELAPSED_W + DUTY_W;           // elapsed * target
    localparam int DSW   = TW + DUTY_W - 1;              // total shifted to top quotient bit
    localparam int CW    = (PW > DSW) ? PW : DSW;
    localparam int CNT_W = $clog2(DUTY_W);
    localparam logic [TW-1:0]    TPS_C    = TW'(TICKS_PER_SECOND);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DUTY_W - 1);
    localparam logic [31:0]      MAX_SEC  = 32'(MAX_RAMP_SECONDS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [SECONDS_W-1:0]    r_ramp_sec;
    logic [DUTY_W-1:0]       r_low_d, r_med_d, r_high_d;
    logic [DUTY_W-1:0]       r_duty;
    logic [LEVEL_W-1:0]      r_level;
    logic                    r_wake;
    logic                    r_ramp;
    logic [ELAPSED_W-1:0]    r_elapsed;
    logic                    r_out_valid;
    logic [DUTY_W-1:0]       r_out_duty;
    logic                    r_out_ramp;
    logic [LEVEL_W-1:0]      r_out_level;

    // datapath, no reset
    logic [TW-1:0]           r_total;
    logic [DUTY_W-1:0]       r_tgt;
    logic [CW-1:0]           r_mcand;
    logic [DUTY_W-1:0]       r_mplier;
    logic [CW-1:0]           r_acc;
    logic [CW-1:0]           r_dsr;
    logic [DUTY_W-1:0]       r_quo;
    logic [CNT_W-1:0]        r_cnt;

    logic                    in_acc;
    logic                    out_acc;
    logic                    div_ge;
    logic                    ramp_done;
    logic [DUTY_W-1:0]       cur_tgt;
    logic [DUTY_W-1:0]       sel_tgt;
    logic [ELAPSED_W-1:0]    n_elapsed;

    assign o_in_stall     = (r_state != S_IDLE);
    assign in_acc         = i_in_valid && (r_state == S_IDLE);
    assign out_acc        = r_out_valid && !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_duty_percent = r_out_duty;
    assign o_ramp_running = r_out_ramp;
    assign o_level_now    = r_out_level;

    // Target duties for the stored and the newly selected level
    assign cur_tgt = level_duty(r_level, r_low_d, r_med_d, r_high_d);
    assign sel_tgt = level_duty(i_level_select, r_low_d, r_med_d, r_high_d);

    // Saturating elapsed step
    assign n_elapsed = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;

    // Division step and ramp end test
    assign div_ge    = (r_acc >= r_dsr);
    assign ramp_done = (r_total == '0) || (CW'(r_elapsed) >= CW'(r_total));

    // Control, state variables, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ramp_sec  <= '0;
            r_low_d     <= 7'd30;
            r_med_d     <= 7'd60;
            r_high_d    <= 7'd100;
            r_duty      <= '0;
            r_level     <= LEVEL_HIGH;
            r_wake      <= 1'b0;
            r_ramp      <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
            r_out_duty  <= '0;
            r_out_ramp  <= 1'b0;
            r_out_level <= LEVEL_HIGH;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RAMP_SECONDS: begin
                        if (32'(i_cfg_data) <= MAX_SEC) r_ramp_sec <= i_cfg_data;
                    end
                    CFG_LOW_DUTY:    r_low_d  <= i_cfg_data[DUTY_W-1:0];
                    CFG_MEDIUM_DUTY: r_med_d  <= i_cfg_data[DUTY_W-1:0];
                    CFG_HIGH_DUTY:   r_high_d <= i_cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end

            // a taken result empties the output unless a new one is loaded now
            if (out_acc && (r_state != S_DONE)) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        // a tick during a ramp goes through the multiply and divide
                        r_state <= ((i_mode == MODE_TICK) && r_ramp) ? S_MUL : S_DONE;
                        case (i_mode)
                            MODE_TICK: begin
                                if (r_ramp) r_elapsed <= n_elapsed;
                            end
                            MODE_SWITCH_ON: begin
                                if (r_wake && (r_ramp_sec != '0)) begin
                                    r_ramp    <= 1'b1;
                                    r_elapsed <= '0;
                                    r_duty    <= '0;
                                end else begin
                                    r_ramp <= 1'b0;
                                    r_duty <= cur_tgt;
                                end
                            end
                            MODE_SWITCH_OFF: begin
                                r_ramp <= 1'b0;
                                r_duty <= '0;
                            end
                            MODE_SET_LEVEL: begin
                                if (i_level_select != LEVEL_NONE) begin
                                    r_level <= i_level_select;
                                    r_ramp  <= 1'b0;
                                    if (r_ramp || (r_duty != '0)) r_duty <= sel_tgt;
                                end
                            end
                            MODE_SET_WAKEUP: begin
                                r_wake <= i_wakeup_value;
                                if (!i_wakeup_value && r_ramp) begin
                                    r_ramp <= 1'b0;
                                    if (r_duty != '0) r_duty <= cur_tgt;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_cnt == LAST_CNT) r_state <= S_CHK;
                end
                S_CHK: begin
                    if (ramp_done) begin
                        r_duty  <= r_tgt;
                        r_ramp  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == LAST_CNT) begin
                        r_duty  <= {r_quo[DUTY_W-2:0], div_ge};
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // load the result beat once the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_duty  <= r_duty;
                        r_out_ramp  <= r_ramp;
                        r_out_level <= r_level;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Serial multiply and restoring divide
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_total  <= TW'(r_ramp_sec) * TPS_C;
                r_tgt    <= cur_tgt;
                r_mcand  <= CW'(n_elapsed);
                r_mplier <= cur_tgt;
                r_acc    <= '0;
                r_cnt    <= '0;
            end
            S_MUL: begin
                if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
            end
            S_CHK: begin
                r_dsr <= CW'(r_total) << (DUTY_W - 1);
                r_quo <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                if (div_ge) r_acc <= r_acc - r_dsr;
                r_dsr <= r_dsr >> 1;
                r_quo <= {r_quo[DUTY_W-2:0], div_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    // A running ramp always has wake-up enabled
    a_ramp_needs_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ramp |-> r_wake)
        else $error("ramp running with wake-up disabled");

    // Applied duty never exceeds full duty
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty <= DUTY_FULL)
        else $error("applied duty above full scale");

    // Partial remainder stays below twice the shifted divisor
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_acc} < {r_dsr, 1'b0}))
        else $error("division remainder out of range");

    // A taken result beat with nothing new to load leaves the output empty
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && (r_state != S_DONE)) |=> !r_out_valid)
        else $error("result beat repeated");

endmodule
